### sv/rsd_pkg.sv
`timescale 1ns / 1ps

package rsd_pkg;

  localparam int unsigned FRAME_BYTES = 64000;

  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned COUNT_W = 14;
  localparam int unsigned LEN_W   = 15;

  // result queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QLVL_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]  OP_LONG   = 8'h80;
  localparam logic [7:0]  OP_RUN    = 8'h00;
  localparam logic [15:0] WORD_STOP = 16'h0000;

  typedef enum logic [2:0] {
    PH_OPCODE,
    PH_WORD_LO,
    PH_WORD_HI,
    PH_RUN_LEN,
    PH_RUN_VAL,
    PH_COPY
  } phase_t;

  typedef enum logic [1:0] {
    KIND_FILL,
    KIND_DONE,
    KIND_EARLY,
    KIND_OVERFLOW
  } kind_t;

  typedef enum logic [3:0] {
    ACT_IDLE,
    ACT_TO_WORD_LO,
    ACT_SAVE_LO,
    ACT_TO_RUN_LEN,
    ACT_SET_RUN,
    ACT_SKIP,
    ACT_COPY_START,
    ACT_RUN,
    ACT_COPY_BYTE,
    ACT_TO_OPCODE,
    ACT_STOP
  } act_t;

  typedef struct packed {
    kind_t               kind;
    logic [ADDR_W-1:0]   address;
    logic [COUNT_W-1:0]  count;
    logic [7:0]          value;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

### sv/rsd_parser.sv
`timescale 1ns / 1ps

module rsd_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic [7:0]      in_byte,
  input  logic            record_start,
  input  logic            record_end,
  output rsd_pkg::push_t  push
);

  rsd_pkg::phase_t                  phase, phase_next, phase_e;
  logic [rsd_pkg::ADDR_W-1:0]       addr, addr_next, addr_e;
  logic [rsd_pkg::COUNT_W-1:0]      pending, pending_next, pending_e;
  logic [7:0]                       lo, lo_next, lo_e;
  logic                             done, done_next, done_e, done_mid;

  rsd_pkg::act_t                    act;
  logic [rsd_pkg::LEN_W-1:0]        len;
  logic [15:0]                      word;
  logic [rsd_pkg::ADDR_W:0]         sum;
  logic                             fits;
  logic                             ovf;

  logic                             main_valid;
  logic                             early;
  rsd_pkg::result_t                 main_res;
  rsd_pkg::result_t                 early_res;

  // a record start clears the parser before the byte is looked at
  always_comb begin
    phase_e   = record_start ? rsd_pkg::PH_OPCODE : phase;
    addr_e    = record_start ? '0 : addr;
    pending_e = record_start ? '0 : pending;
    lo_e      = record_start ? '0 : lo;
    done_e    = record_start ? 1'b0 : done;
  end

  // decode
  always_comb begin
    act  = rsd_pkg::ACT_IDLE;
    len  = '0;
    word = {in_byte, lo_e};
    if (!done_e) begin
      case (phase_e)
        rsd_pkg::PH_OPCODE: begin
          if (in_byte == rsd_pkg::OP_LONG) begin
            act = rsd_pkg::ACT_TO_WORD_LO;
          end else if (in_byte[7]) begin
            act = rsd_pkg::ACT_SKIP;
            len = {8'b0, in_byte[6:0]};
          end else if (in_byte == rsd_pkg::OP_RUN) begin
            act = rsd_pkg::ACT_TO_RUN_LEN;
          end else begin
            act = rsd_pkg::ACT_COPY_START;
            len = {7'b0, in_byte};
          end
        end
        rsd_pkg::PH_WORD_LO: act = rsd_pkg::ACT_SAVE_LO;
        rsd_pkg::PH_WORD_HI: begin
          if (word == rsd_pkg::WORD_STOP) begin
            act = rsd_pkg::ACT_STOP;
          end else if (!word[15]) begin
            act = rsd_pkg::ACT_SKIP;
            len = word[14:0];
          end else if (word[14]) begin
            act = rsd_pkg::ACT_SET_RUN;
            len = {1'b0, word[13:0]};
          end else begin
            act = rsd_pkg::ACT_COPY_START;
            len = {1'b0, word[13:0]};
          end
        end
        rsd_pkg::PH_RUN_LEN: begin
          act = rsd_pkg::ACT_SET_RUN;
          len = {7'b0, in_byte};
        end
        rsd_pkg::PH_RUN_VAL: begin
          act = rsd_pkg::ACT_RUN;
          len = {1'b0, pending_e};
        end
        rsd_pkg::PH_COPY: begin
          if (pending_e == '0 ||
              addr_e >= rsd_pkg::ADDR_W'(rsd_pkg::FRAME_BYTES)) begin
            act = rsd_pkg::ACT_TO_OPCODE;
          end else begin
            act = rsd_pkg::ACT_COPY_BYTE;
          end
        end
        default: act = rsd_pkg::ACT_TO_OPCODE;
      endcase
    end
  end

  // one bounds check shared by skip, run and copy start
  always_comb begin
    sum  = {1'b0, addr_e} + {2'b0, len};
    fits = sum <= (rsd_pkg::ADDR_W + 1)'(rsd_pkg::FRAME_BYTES);
    ovf  = (act == rsd_pkg::ACT_SKIP || act == rsd_pkg::ACT_COPY_START ||
            act == rsd_pkg::ACT_RUN) && !fits;
  end

  // next state
  always_comb begin
    phase_next   = phase_e;
    addr_next    = addr_e;
    pending_next = pending_e;
    lo_next      = lo_e;
    done_mid     = done_e;
    if (ovf) begin
      done_mid   = 1'b1;
      phase_next = rsd_pkg::PH_OPCODE;
    end else begin
      case (act)
        rsd_pkg::ACT_TO_WORD_LO: phase_next = rsd_pkg::PH_WORD_LO;
        rsd_pkg::ACT_SAVE_LO: begin
          lo_next    = in_byte;
          phase_next = rsd_pkg::PH_WORD_HI;
        end
        rsd_pkg::ACT_TO_RUN_LEN: phase_next = rsd_pkg::PH_RUN_LEN;
        rsd_pkg::ACT_SET_RUN: begin
          pending_next = len[rsd_pkg::COUNT_W-1:0];
          phase_next   = rsd_pkg::PH_RUN_VAL;
        end
        rsd_pkg::ACT_SKIP: begin
          addr_next  = sum[rsd_pkg::ADDR_W-1:0];
          phase_next = rsd_pkg::PH_OPCODE;
        end
        rsd_pkg::ACT_COPY_START: begin
          pending_next = len[rsd_pkg::COUNT_W-1:0];
          phase_next   = (len != '0) ? rsd_pkg::PH_COPY : rsd_pkg::PH_OPCODE;
        end
        rsd_pkg::ACT_RUN: begin
          addr_next    = sum[rsd_pkg::ADDR_W-1:0];
          pending_next = '0;
          phase_next   = rsd_pkg::PH_OPCODE;
        end
        rsd_pkg::ACT_COPY_BYTE: begin
          addr_next    = addr_e + rsd_pkg::ADDR_W'(1);
          pending_next = pending_e - rsd_pkg::COUNT_W'(1);
          if (pending_e == rsd_pkg::COUNT_W'(1)) begin
            phase_next = rsd_pkg::PH_OPCODE;
          end
        end
        rsd_pkg::ACT_TO_OPCODE: begin
          pending_next = '0;
          phase_next   = rsd_pkg::PH_OPCODE;
        end
        rsd_pkg::ACT_STOP: begin
          done_mid   = 1'b1;
          phase_next = rsd_pkg::PH_OPCODE;
        end
        default: ;
      endcase
    end
    done_next = done_mid;
    // record ended without stop marker or error
    if (record_end && !done_mid) begin
      done_next  = 1'b1;
      phase_next = rsd_pkg::PH_OPCODE;
    end
  end

  // results
  always_comb begin
    main_valid       = 1'b0;
    main_res.kind    = rsd_pkg::KIND_FILL;
    main_res.address = addr_e;
    main_res.count   = '0;
    main_res.value   = '0;
    if (ovf) begin
      main_valid    = 1'b1;
      main_res.kind = rsd_pkg::KIND_OVERFLOW;
    end else if (act == rsd_pkg::ACT_STOP) begin
      main_valid    = 1'b1;
      main_res.kind = rsd_pkg::KIND_DONE;
    end else if (act == rsd_pkg::ACT_RUN && pending_e != '0) begin
      main_valid     = 1'b1;
      main_res.count = pending_e;
      main_res.value = in_byte;
    end else if (act == rsd_pkg::ACT_COPY_BYTE) begin
      main_valid     = 1'b1;
      main_res.count = rsd_pkg::COUNT_W'(1);
      main_res.value = in_byte;
    end

    early             = record_end && !done_mid;
    early_res.kind    = rsd_pkg::KIND_EARLY;
    early_res.address = addr_next;
    early_res.count   = '0;
    early_res.value   = '0;

    push.first  = main_valid ? main_res : early_res;
    push.second = early_res;
    push.num    = advance ? ({1'b0, main_valid} + {1'b0, early}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= rsd_pkg::PH_OPCODE;
      addr    <= '0;
      pending <= '0;
      lo      <= '0;
      done    <= 1'b0;
    end else if (advance) begin
      phase   <= phase_next;
      addr    <= addr_next;
      pending <= pending_next;
      lo      <= lo_next;
      done    <= done_next;
    end
  end

endmodule

### sv/rsd_queue.sv
`timescale 1ns / 1ps

module rsd_queue (
  input  logic              clk,
  input  logic              rst,
  input  rsd_pkg::push_t    push,
  input  logic              out_stall,
  output logic              room,
  output logic              out_valid,
  output rsd_pkg::result_t  head
);

  rsd_pkg::result_t                 mem [rsd_pkg::QUEUE_DEPTH];
  logic [rsd_pkg::QPTR_W-1:0]       wr_ptr, rd_ptr;
  logic [rsd_pkg::QLVL_W-1:0]       level, level_next;
  logic                             pop;

  assign out_valid = level != '0;
  assign head      = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;
  // two free slots so a byte that yields two results never blocks
  assign room      = level <= rsd_pkg::QLVL_W'(rsd_pkg::QUEUE_DEPTH - 2);

  assign level_next = level + rsd_pkg::QLVL_W'(push.num) - rsd_pkg::QLVL_W'(pop);

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.num == 2'd2) begin
      mem[wr_ptr + rsd_pkg::QPTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + rsd_pkg::QPTR_W'(push.num);
      rd_ptr <= rd_ptr + rsd_pkg::QPTR_W'(pop);
      level  <= level_next;
    end
  end

endmodule

### sv/run_skip_dump_frame_decoder_top.sv
`timescale 1ns / 1ps

// Run/skip/dump frame record decoder. One compressed byte enters per input
// transaction (in_byte, record_start, record_end on in_valid/in_stall) and
// frame-store commands leave one per output transaction (kind, address,
// count, value on out_valid/out_stall): fills, frame done, early record end
// and frame overflow.
// A byte taken is held in an input register and parsed from there; its
// results are written into the result queue, so with an empty queue
// out_valid rises once the byte has passed the input register and the
// queue write.
// Throughput is one byte per cycle while each byte gives at most one result
// and the receiver takes it; a byte that gives two (a fill plus the early
// end flag) puts both into the queue. A four-entry result queue sits
// between parser and output, and the parser takes a byte only while two
// entries are free.
// When the receiver stalls, results stay queued and unchanged; with fewer than
// two free entries in_stall rises while a byte is held and that byte waits.
// Reset clears the parser to wait for an opcode at address zero and empties
// the queue; no transaction is lost across a stall.

module run_skip_dump_frame_decoder_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [7:0]   in_byte,
  input  logic         record_start,
  input  logic         record_end,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [1:0]   kind,
  output logic [15:0]  address,
  output logic [13:0]  count,
  output logic [7:0]   value
);

  logic              hold_valid;
  logic [7:0]        byte_q;
  logic              start_q;
  logic              end_q;
  logic              room;
  logic              advance;
  logic              accept;
  rsd_pkg::push_t    push;
  rsd_pkg::result_t  head;

  assign advance  = hold_valid && room;
  assign in_stall = hold_valid && !room;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_q  <= in_byte;
      start_q <= record_start;
      end_q   <= record_end;
    end
  end

  rsd_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .in_byte      (byte_q),
    .record_start (start_q),
    .record_end   (end_q),
    .push         (push)
  );

  rsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_stall (out_stall),
    .room      (room),
    .out_valid (out_valid),
    .head      (head)
  );

  assign kind    = head.kind;
  assign address = head.address;
  assign count   = head.count;
  assign value   = head.value;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned STUCK_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS = 1800;

  typedef struct {
    logic [7:0] data;
    logic       first;
    logic       last;
    bit         hold;
    bit [1:0]   ph;
  } feed_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic        record_start = 1'b0;
  logic        record_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [15:0] address;
  logic [13:0] count;
  logic [7:0]  value;

  int send_idle_pct[3]   = '{22, 46, 0};
  int recv_stall_pct[3]  = '{46, 22, 0};
  bit [1:0] feed_ph = '0;

  feed_t             byte_feed[$];
  logic [7:0]        rec_bytes[$];
  rsd_pkg::result_t  decoded_cmds[$];
  int unsigned n_items = 0;
  int unsigned taken = 0;
  int unsigned bad_cmds = 0;
  int unsigned stuck_cycles = 0;

  // decoder state mirror
  rsd_pkg::phase_t dec_phase = rsd_pkg::PH_OPCODE;
  int unsigned dec_addr = 0;
  int unsigned dec_left = 0;
  logic [7:0]  dec_lo = '0;
  bit          dec_halted = 1'b0;

  run_skip_dump_frame_decoder_top uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .record_start(record_start),
    .record_end(record_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .address(address),
    .count(count),
    .value(value)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void emit_cmd(rsd_pkg::kind_t k, int unsigned a, int unsigned c,
                                   logic [7:0] v);
    rsd_pkg::result_t r;
    r.kind = k;
    r.address = a[15:0];
    r.count = c[13:0];
    r.value = v;
    decoded_cmds.push_back(r);
  endfunction

  function automatic bit fits_frame(int unsigned n);
    return dec_addr + n <= rsd_pkg::FRAME_BYTES;
  endfunction

  function automatic void flag_overflow();
    emit_cmd(rsd_pkg::KIND_OVERFLOW, dec_addr, 0, 8'h00);
    dec_halted = 1'b1;
    dec_phase = rsd_pkg::PH_OPCODE;
  endfunction

  function automatic void skip_ahead(int unsigned n);
    if (!fits_frame(n)) begin
      flag_overflow();
    end else begin
      dec_addr += n;
      dec_phase = rsd_pkg::PH_OPCODE;
    end
  endfunction

  // whole copy is checked against the frame end before any literal
  function automatic void open_copy(int unsigned n);
    if (!fits_frame(n)) begin
      flag_overflow();
    end else begin
      dec_left = n;
      dec_phase = (n != 0) ? rsd_pkg::PH_COPY : rsd_pkg::PH_OPCODE;
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic first, logic last);
    logic [15:0] w;
    if (first) begin
      dec_phase = rsd_pkg::PH_OPCODE;
      dec_addr = 0;
      dec_left = 0;
      dec_lo = '0;
      dec_halted = 1'b0;
    end
    if (!dec_halted) begin
      case (dec_phase)
        rsd_pkg::PH_OPCODE: begin
          if (b == rsd_pkg::OP_LONG) dec_phase = rsd_pkg::PH_WORD_LO;
          else if (b[7]) skip_ahead(b[6:0]);
          else if (b == rsd_pkg::OP_RUN) dec_phase = rsd_pkg::PH_RUN_LEN;
          else open_copy(b);
        end
        rsd_pkg::PH_WORD_LO: begin
          dec_lo = b;
          dec_phase = rsd_pkg::PH_WORD_HI;
        end
        rsd_pkg::PH_WORD_HI: begin
          w = {b, dec_lo};
          if (w == rsd_pkg::WORD_STOP) begin
            emit_cmd(rsd_pkg::KIND_DONE, dec_addr, 0, 8'h00);
            dec_halted = 1'b1;
            dec_phase = rsd_pkg::PH_OPCODE;
          end else if (!w[15]) begin
            skip_ahead(w);
          end else if (w[14]) begin
            dec_left = w[13:0];
            dec_phase = rsd_pkg::PH_RUN_VAL;
          end else begin
            open_copy(w[13:0]);
          end
        end
        rsd_pkg::PH_RUN_LEN: begin
          dec_left = b;
          dec_phase = rsd_pkg::PH_RUN_VAL;
        end
        rsd_pkg::PH_RUN_VAL: begin
          if (!fits_frame(dec_left)) begin
            flag_overflow();
          end else begin
            if (dec_left != 0) begin
              emit_cmd(rsd_pkg::KIND_FILL, dec_addr, dec_left, b);
              dec_addr += dec_left;
            end
            dec_left = 0;
            dec_phase = rsd_pkg::PH_OPCODE;
          end
        end
        rsd_pkg::PH_COPY: begin
          if (dec_left == 0 || dec_addr >= rsd_pkg::FRAME_BYTES) begin
            dec_phase = rsd_pkg::PH_OPCODE;
            dec_left = 0;
          end else begin
            emit_cmd(rsd_pkg::KIND_FILL, dec_addr, 1, b);
            dec_addr += 1;
            dec_left -= 1;
            if (dec_left == 0) dec_phase = rsd_pkg::PH_OPCODE;
          end
        end
        default: dec_phase = rsd_pkg::PH_OPCODE;
      endcase
    end
    // record ran out before a stop marker
    if (last && !dec_halted) begin
      emit_cmd(rsd_pkg::KIND_EARLY, dec_addr, 0, 8'h00);
      dec_halted = 1'b1;
      dec_phase = rsd_pkg::PH_OPCODE;
    end
  endfunction

  task automatic add_literals(int unsigned n);
    repeat (n) rec_bytes.push_back(8'($urandom));
  endtask

  task automatic add_word(logic [15:0] w);
    rec_bytes.push_back(rsd_pkg::OP_LONG);
    rec_bytes.push_back(w[7:0]);
    rec_bytes.push_back(w[15:8]);
  endtask

  task automatic add_skip(int unsigned n);
    rec_bytes.push_back({1'b1, n[6:0]});
  endtask

  task automatic add_run(int unsigned n, logic [7:0] v);
    rec_bytes.push_back(rsd_pkg::OP_RUN);
    rec_bytes.push_back(n[7:0]);
    rec_bytes.push_back(v);
  endtask

  task automatic add_copy(int unsigned n);
    rec_bytes.push_back(n[7:0]);
    add_literals(n);
  endtask

  task automatic add_wskip(int unsigned n);
    add_word({1'b0, n[14:0]});
  endtask

  task automatic add_wrun(int unsigned n, logic [7:0] v);
    add_word({2'b11, n[13:0]});
    rec_bytes.push_back(v);
  endtask

  task automatic add_wcopy(int unsigned n);
    add_word({2'b10, n[13:0]});
    add_literals(n);
  endtask

  task automatic add_stop();
    add_word(rsd_pkg::WORD_STOP);
  endtask

  task automatic add_command();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 20) add_skip($urandom_range(1, 127));
    else if (pick < 35)
      add_run(($urandom_range(3) == 0) ? 0 : $urandom_range(255), 8'($urandom));
    else if (pick < 55)
      add_copy(($urandom_range(99) < 3) ? $urandom_range(100, 127) : $urandom_range(1, 6));
    else if (pick < 70)
      add_wskip(($urandom_range(9) < 7) ? $urandom_range(1, 2000) : $urandom_range(1, 32767));
    else if (pick < 85)
      add_wrun(($urandom_range(9) == 0) ? 0 : $urandom_range(16383), 8'($urandom));
    else add_wcopy($urandom_range(6));
  endtask

  task automatic push_record(bit [1:0] ph, bit with_start, bit with_end);
    feed_t f;
    foreach (rec_bytes[i]) begin
      f.data = rec_bytes[i];
      f.first = with_start && (i == 0);
      f.last = with_end && (i == rec_bytes.size() - 1);
      f.hold = 1'b0;
      f.ph = ph;
      byte_feed.push_back(f);
    end
    n_items += rec_bytes.size();
    rec_bytes.delete();
  endtask

  // sender waits here until every expected command has come out
  task automatic add_hold(bit [1:0] ph);
    feed_t f;
    f.data = '0;
    f.first = 1'b0;
    f.last = 1'b0;
    f.hold = 1'b1;
    f.ph = ph;
    byte_feed.push_back(f);
  endtask

  // input driver
  always @(posedge clk) begin : feed_drive
    feed_t f;
    bit load;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      load = 1'b0;
      if (byte_feed.size() != 0 && byte_feed[0].hold && !in_valid &&
          decoded_cmds.size() == 0)
        void'(byte_feed.pop_front());
      if (byte_feed.size() != 0 && !byte_feed[0].hold &&
          $urandom_range(99) >= send_idle_pct[byte_feed[0].ph]) begin
        f = byte_feed.pop_front();
        in_byte <= f.data;
        record_start <= f.first;
        record_end <= f.last;
        feed_ph <= f.ph;
        load = 1'b1;
      end
      in_valid <= load;
    end
  end

  // output monitor, prediction and watchdog
  always @(posedge clk) begin : observe
    rsd_pkg::result_t want;
    bit moved;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      moved = 1'b0;
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        moved = 1'b1;
        if (decoded_cmds.size() == 0) begin
          bad_cmds++;
          if (bad_cmds <= 10)
            $display("unexpected command: kind=%0d address=%0d count=%0d value=%0h",
                     kind, address, count, value);
        end else begin
          want = decoded_cmds.pop_front();
          if (kind !== want.kind || address !== want.address ||
              count !== want.count || value !== want.value) begin
            bad_cmds++;
            if (bad_cmds <= 10)
              $display({"command mismatch: expected kind=%0d address=%0d count=%0d ",
                        "value=%0h, got kind=%0d address=%0d count=%0d value=%0h"},
                       want.kind, want.address, want.count, want.value,
                       kind, address, count, value);
          end
        end
      end
      // inputs accepted this edge cannot show up before the next one
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        decode_byte(in_byte, record_start, record_end);
        taken++;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct[feed_ph]);
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("no transaction for %0d cycles", STUCK_LIMIT);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    bit [1:0] ph;
    bit [1:0] last_ph;
    int unsigned pick;
    int unsigned cut;

    // bytes before any record_start parse as a record begun at reset
    add_skip(5);
    add_copy(1);
    add_stop();
    push_record(0, 1'b0, 1'b1);
    // fill to exactly the frame end, then a copy that overflows
    add_wskip(32767);
    add_wskip(31230);
    add_run(3, 8'hFF);
    add_copy(1);
    push_record(0, 1'b1, 1'b1);
    // zero-length run, word run, then a fill plus early end on one byte
    add_run(0, 8'h33);
    add_wrun(2, 8'h00);
    add_copy(2);
    push_record(0, 1'b1, 1'b1);
    // single-byte record cut short inside a word opcode
    rec_bytes.push_back(rsd_pkg::OP_LONG);
    push_record(0, 1'b1, 1'b1);
    add_hold(0);

    last_ph = 0;
    while (n_items < RANDOM_ITEMS) begin
      ph = (n_items < RANDOM_ITEMS / 3) ? 2'd0 :
           ((n_items < 2 * RANDOM_ITEMS / 3) ? 2'd1 : 2'd2);
      if (ph != last_ph) begin
        add_hold(ph);
        last_ph = ph;
      end
      pick = $urandom_range(99);
      if (pick < 12) begin
        add_literals($urandom_range(1, 8));
        push_record(ph, 1'b1, 1'($urandom_range(1)));
      end else begin
        repeat ($urandom_range(1, 12)) add_command();
        add_stop();
        if (pick < 24) begin
          cut = $urandom_range(1, rec_bytes.size() - 1);
          while (rec_bytes.size() > cut) void'(rec_bytes.pop_back());
        end else if (pick < 30) begin
          add_literals($urandom_range(1, 3));
        end
        push_record(ph, $urandom_range(19) != 0, 1'b1);
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (taken < n_items || decoded_cmds.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (bad_cmds == 0 && decoded_cmds.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
